// ===== hdl/sfud_pkg.sv =====
// ---------------------------------------------------------------------------
// sfud_pkg: shared definitions for the stereo audio FIFO
// Widths, constants, codes and transfer structs used by the channel
// interfaces, the datapath units and the top level.
// ---------------------------------------------------------------------------
`default_nettype none

package sfud_pkg;

   // Ring geometry
   localparam int PAIR_DEPTH = 2048;
   localparam int IDX_W      = $clog2(PAIR_DEPTH);
   localparam int CNT_W      = $clog2(PAIR_DEPTH + 1);

   // Field widths
   localparam int OP_W       = 2;
   localparam int IN_W       = 18;
   localparam int SAMPLE_W   = 16;
   localparam int PAIR_W     = 2 * SAMPLE_W;
   localparam int GAIN_W     = 17;
   localparam int PREBUF_W   = 12;
   localparam int FILL_W     = 12;
   localparam int PROD_W     = SAMPLE_W + GAIN_W;
   localparam int CMP_W      = (CNT_W > PREBUF_W) ? CNT_W : PREBUF_W;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = GAIN_W;

   // Arithmetic constants (Q1.16 factors, Q1.15 full scale)
   localparam logic [GAIN_W-1:0]          UNITY_GAIN  = 17'd65536;
   localparam logic [GAIN_W-1:0]          DECAY_Q16   = 17'd63570;
   localparam logic [PREBUF_W-1:0]        PREBUF_RST  = 12'd1024;
   localparam logic signed [IN_W-1:0]     IN_POS_FS   = 18'sd32767;
   localparam logic signed [IN_W-1:0]     IN_NEG_FS   = -18'sd32767;
   localparam logic signed [SAMPLE_W-1:0] POS_FS      = 16'sd32767;
   localparam logic signed [SAMPLE_W-1:0] NEG_FS      = -16'sd32767;

   // Operation codes
   typedef enum logic [OP_W-1:0] {
      OP_PUSH  = 2'd0,
      OP_PULL  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VOLUME = 2'd0,
      CSR_PREBUF = 2'd1,
      CSR_PLAY   = 2'd2
   } csr_index_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL_L,
      ST_MUL_R,
      ST_COMMIT
   } state_type;

   // Shared multiplier request
   typedef struct packed {
      logic                       load;
      logic signed [SAMPLE_W-1:0] operand;
      logic [GAIN_W-1:0]          factor;
   } mul_req_type;

   // Ring memory write and read requests
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [PAIR_W-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } ram_rd_type;

   // Ring index advance with wrap
   function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(PAIR_DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/sfud_req_if.sv =====
// ---------------------------------------------------------------------------
// sfud_req_if: request channel
// Valid/ready channel carrying one operation and a stereo input pair.
// ---------------------------------------------------------------------------
`default_nettype none

interface sfud_req_if;
   import sfud_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [OP_W-1:0]        op;
   logic signed [IN_W-1:0] in_left;
   logic signed [IN_W-1:0] in_right;

   modport source (output valid, output op, output in_left, output in_right, input ready);
   modport sink   (input valid, input op, input in_left, input in_right, output ready);
endinterface

`default_nettype wire

// ===== hdl/sfud_rsp_if.sv =====
// ---------------------------------------------------------------------------
// sfud_rsp_if: response channel
// Valid/ready channel carrying the output pair and the buffer status.
// ---------------------------------------------------------------------------
`default_nettype none

interface sfud_rsp_if;
   import sfud_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] out_left;
   logic signed [SAMPLE_W-1:0] out_right;
   logic                       underrun;
   logic                       dropped;
   logic                       playing;
   logic [FILL_W-1:0]          fill_pairs;

   modport source (output valid, output out_left, output out_right, output underrun,
                   output dropped, output playing, output fill_pairs, input ready);
   modport sink   (input valid, input out_left, input out_right, input underrun,
                   input dropped, input playing, input fill_pairs, output ready);
endinterface

`default_nettype wire

// ===== hdl/sfud_mul_unit.sv =====
// ---------------------------------------------------------------------------
// sfud_mul_unit: shared sign-magnitude Q1.16 scaler
// Computes sign(x) * ((|x| * factor) >> 16), truncated toward zero, with
// a registered result. Used for volume and for decay, one sample a cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module sfud_mul_unit (
   input  wire logic                                 clock,
   input  wire sfud_pkg::mul_req_type                mul_req,
   output logic signed [sfud_pkg::SAMPLE_W-1:0]      result_ff
);
   import sfud_pkg::*;

   logic [SAMPLE_W-1:0]        mag;
   logic [PROD_W-1:0]          prod;
   logic [GAIN_W-1:0]          scaled;
   logic [GAIN_W-1:0]          scaled_neg;
   logic signed [SAMPLE_W-1:0] result_in;

   // Magnitude, product, sign restore
   always_comb begin
      mag        = mul_req.operand[SAMPLE_W-1] ? (~mul_req.operand + 1'b1) : mul_req.operand;
      prod       = PROD_W'(mag) * PROD_W'(mul_req.factor);
      scaled     = prod[PROD_W-1:SAMPLE_W];
      scaled_neg = ~scaled + 1'b1;
      result_in  = mul_req.operand[SAMPLE_W-1] ? scaled_neg[SAMPLE_W-1:0]
                                               : scaled[SAMPLE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (mul_req.load) begin
         result_ff <= result_in;
      end
   end
endmodule

`default_nettype wire

// ===== hdl/sfud_ring_ram.sv =====
// ---------------------------------------------------------------------------
// sfud_ring_ram: pair storage
// One write port and one read port with registered read data; left sample
// in the upper half of each word, right sample in the lower half.
// ---------------------------------------------------------------------------
`default_nettype none

module sfud_ring_ram (
   input  wire logic                          clock,
   input  wire sfud_pkg::ram_wr_type          wr_req,
   input  wire sfud_pkg::ram_rd_type          rd_req,
   output logic [sfud_pkg::PAIR_W-1:0]        rd_data_ff
);
   import sfud_pkg::*;

   logic [PAIR_W-1:0] mem [PAIR_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         mem[wr_req.addr] <= wr_req.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_req.en) begin
         rd_data_ff <= mem[rd_req.addr];
      end
   end
endmodule

`default_nettype wire

// ===== hdl/stereo_audio_fifo_underrun_decay.sv =====
// ---------------------------------------------------------------------------
// stereo_audio_fifo_underrun_decay: audio output FIFO with pre-buffer
// Request channel (req_chan) takes push, pull, clear or no-op transactions;
// every request gives exactly one transaction on the response channel
// (rsp_chan). Registers on the csr_ port set volume, the pre-buffer
// threshold and the play enable; write them only while the block is idle.
// A push and a pull that underruns pass through ST_MUL_L and ST_MUL_R
// before ST_COMMIT loads the response register: both samples go through
// one shared multiplier, left then right. A pull with data, a pull while
// stopped, a clear and a no-op go from acceptance straight to ST_COMMIT;
// the ring memory read is issued at acceptance. A new request is taken
// only once the sequencer is back in ST_IDLE.
// One request is in flight at a time; req_chan.ready is high whenever the
// sequencer is idle, also while a response still waits to be taken.
// When rsp_chan stalls, the finished request holds in its last step until
// the response register frees, then commits its state changes.
// Reset (synchronous) empties the ring, stops playback, zeroes the last
// pair and restores unity volume, a threshold of 1024 and play disabled.
// Ring contents need no clearing pass; only written entries are returned.
// ---------------------------------------------------------------------------
`default_nettype none

module stereo_audio_fifo_underrun_decay (
   input  wire logic                             clock,
   input  wire logic                             reset,
   sfud_req_if.sink                              req_chan,
   sfud_rsp_if.source                            rsp_chan,
   input  wire logic                             csr_we,
   input  wire logic [sfud_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [sfud_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import sfud_pkg::*;

   // Clamp to plus or minus full scale
   function automatic logic signed [SAMPLE_W-1:0] clamp_fs(input logic signed [IN_W-1:0] x);
      if (x > IN_POS_FS) begin
         return POS_FS;
      end else if (x < IN_NEG_FS) begin
         return NEG_FS;
      end else begin
         return x[SAMPLE_W-1:0];
      end
   endfunction

   state_type                  state_ff, state_in;

   // Configuration
   logic [GAIN_W-1:0]          gain_ff;
   logic [PREBUF_W-1:0]        prebuf_ff;
   logic                       play_en_ff;

   // Ring control state
   logic [IDX_W-1:0]           rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]           wr_idx_ff, wr_idx_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       active_ff, active_in;
   logic signed [SAMPLE_W-1:0] last_l_ff, last_l_in;
   logic signed [SAMPLE_W-1:0] last_r_ff, last_r_in;

   // Latched request and partial result
   logic [OP_W-1:0]            op_ff;
   logic signed [SAMPLE_W-1:0] left_ff, right_ff;
   logic signed [SAMPLE_W-1:0] scaled_l_ff, scaled_l_in;

   // Response register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] out_l_ff, out_l_in;
   logic signed [SAMPLE_W-1:0] out_r_ff, out_r_in;
   logic                       underrun_ff, underrun_in;
   logic                       dropped_ff, dropped_in;
   logic                       playing_ff, playing_in;
   logic [FILL_W-1:0]          fill_ff, fill_in;

   logic                       req_fire;
   logic                       slot_free;
   logic [GAIN_W-1:0]          gain_eff;
   logic                       op_is_push;
   mul_req_type                mul_req;
   logic signed [SAMPLE_W-1:0] mul_res;
   ram_wr_type                 wr_req;
   ram_rd_type                 rd_req;
   logic [PAIR_W-1:0]          rd_data;

   // Shared multiplier and ring memory
   sfud_mul_unit u_mul (
      .clock     (clock),
      .mul_req   (mul_req),
      .result_ff (mul_res)
   );

   sfud_ring_ram u_ram (
      .clock      (clock),
      .wr_req     (wr_req),
      .rd_req     (rd_req),
      .rd_data_ff (rd_data)
   );

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_left  = out_l_ff;
   assign rsp_chan.out_right = out_r_ff;
   assign rsp_chan.underrun  = underrun_ff;
   assign rsp_chan.dropped   = dropped_ff;
   assign rsp_chan.playing   = playing_ff;
   assign rsp_chan.fill_pairs = fill_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff    <= UNITY_GAIN;
         prebuf_ff  <= PREBUF_RST;
         play_en_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_VOLUME: gain_ff    <= csr_wdata[GAIN_W-1:0];
            CSR_PREBUF: prebuf_ff  <= csr_wdata[PREBUF_W-1:0];
            CSR_PLAY:   play_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         count_ff     <= '0;
         active_ff    <= 1'b0;
         last_l_ff    <= '0;
         last_r_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_idx_ff    <= rd_idx_in;
         wr_idx_ff    <= wr_idx_in;
         count_ff     <= count_in;
         active_ff    <= active_in;
         last_l_ff    <= last_l_in;
         last_r_ff    <= last_r_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req_chan.op;
         left_ff  <= clamp_fs(req_chan.in_left);
         right_ff <= clamp_fs(req_chan.in_right);
      end
      scaled_l_ff <= scaled_l_in;
      out_l_ff    <= out_l_in;
      out_r_ff    <= out_r_in;
      underrun_ff <= underrun_in;
      dropped_ff  <= dropped_in;
      playing_ff  <= playing_in;
      fill_ff     <= fill_in;
   end

   // Sequencer: next state, datapath control and commit
   always_comb begin
      req_fire   = req_chan.valid && (state_ff == ST_IDLE);
      slot_free  = !rsp_valid_ff || rsp_chan.ready;
      gain_eff   = (gain_ff > UNITY_GAIN) ? UNITY_GAIN : gain_ff;
      op_is_push = (op_ff == OP_PUSH);

      state_in     = state_ff;
      rd_idx_in    = rd_idx_ff;
      wr_idx_in    = wr_idx_ff;
      count_in     = count_ff;
      active_in    = active_ff;
      last_l_in    = last_l_ff;
      last_r_in    = last_r_ff;
      scaled_l_in  = scaled_l_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      out_l_in     = out_l_ff;
      out_r_in     = out_r_ff;
      underrun_in  = underrun_ff;
      dropped_in   = dropped_ff;
      playing_in   = playing_ff;
      fill_in      = fill_ff;

      mul_req.load    = 1'b0;
      mul_req.operand = op_is_push ? left_ff : last_l_ff;
      mul_req.factor  = op_is_push ? gain_eff : DECAY_Q16;

      wr_req.en   = 1'b0;
      wr_req.addr = wr_idx_ff;
      wr_req.data = {scaled_l_ff, mul_res};

      // read the oldest pair as the request is taken
      rd_req.en   = req_fire;
      rd_req.addr = rd_idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if ((req_chan.op == OP_PUSH) ||
                   ((req_chan.op == OP_PULL) && active_ff && (count_ff == '0))) begin
                  state_in = ST_MUL_L;
               end else begin
                  state_in = ST_COMMIT;
               end
            end
         end
         ST_MUL_L: begin
            mul_req.load = 1'b1;
            state_in     = ST_MUL_R;
         end
         ST_MUL_R: begin
            mul_req.load    = 1'b1;
            mul_req.operand = op_is_push ? right_ff : last_r_ff;
            scaled_l_in     = mul_res;
            state_in        = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (slot_free) begin
               out_l_in    = '0;
               out_r_in    = '0;
               underrun_in = 1'b0;
               dropped_in  = 1'b0;
               case (op_ff)
                  OP_PUSH: begin
                     if (count_ff >= CNT_W'(PAIR_DEPTH)) begin
                        dropped_in = 1'b1;
                     end else begin
                        wr_req.en = 1'b1;
                        wr_idx_in = next_index(wr_idx_ff);
                        count_in  = count_ff + 1'b1;
                        if (play_en_ff && !active_ff &&
                            (CMP_W'(count_in) >= CMP_W'(prebuf_ff))) begin
                           active_in = 1'b1;
                        end
                     end
                  end
                  OP_PULL: begin
                     if (active_ff) begin
                        if (count_ff != '0) begin
                           last_l_in = rd_data[PAIR_W-1:SAMPLE_W];
                           last_r_in = rd_data[SAMPLE_W-1:0];
                           rd_idx_in = next_index(rd_idx_ff);
                           count_in  = count_ff - 1'b1;
                        end else begin
                           underrun_in = 1'b1;
                           last_l_in   = scaled_l_ff;
                           last_r_in   = mul_res;
                        end
                        out_l_in = last_l_in;
                        out_r_in = last_r_in;
                     end
                  end
                  OP_CLEAR: begin
                     rd_idx_in = '0;
                     wr_idx_in = '0;
                     count_in  = '0;
                     active_in = 1'b0;
                  end
                  default: ;
               endcase
               playing_in   = active_in;
               fill_in      = FILL_W'(count_in);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(PAIR_DEPTH))
      else $error("pair count above ring depth");

   a_empty_idx: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (rd_idx_ff == wr_idx_ff))
      else $error("empty ring with unequal indexes");

   a_underrun_playing: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && underrun_ff) |-> playing_ff)
      else $error("underrun reported while stopped");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && dropped_ff) |-> (fill_ff == FILL_W'(PAIR_DEPTH)))
      else $error("push dropped with ring not full");

endmodule

`default_nettype wire

// ===== sim/fifo_playback_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fifo_playback_checker: response checker for the stereo audio FIFO
// Watches the request, response and register ports. Every accepted request
// runs through a cycle-free model of the ring, the pre-buffer start and the
// underrun decay. The predicted response is queued and compared field by
// field with the next response transaction. Mismatches are counted and
// handed to the test top.
// ---------------------------------------------------------------------------

module fifo_playback_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   sfud_req_if                                  req_view,
   sfud_rsp_if                                  rsp_view,
   input  wire logic                            csr_we,
   input  wire logic [sfud_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sfud_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                                   error_count,
   output int                                   outstanding
);
   import sfud_pkg::*;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic                       underrun;
      logic                       dropped;
      logic                       playing;
      logic [FILL_W-1:0]          fill;
   } pair_result_type;

   // Responses predicted but not yet seen, oldest first
   pair_result_type expected_pairs[$];

   // Model copy of the ring and playback state
   logic [PAIR_W-1:0] ring_copy [PAIR_DEPTH];
   int unsigned       read_pos;
   int unsigned       write_pos;
   int unsigned       stored_pairs;
   int                held_left;
   int                held_right;
   logic              playback_on;

   // Model copy of the registers
   logic [GAIN_W-1:0]   volume;
   logic [PREBUF_W-1:0] start_level;
   logic                play_allowed;

   task automatic flag_error(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         flag_error($sformatf("%s got %0d, expected %0d", name, got, want));
   endtask

   function automatic int clamp_full_scale(input logic signed [IN_W-1:0] x);
      int v;
      v = x;
      if (v > int'(POS_FS))
         return int'(POS_FS);
      if (v < int'(NEG_FS))
         return int'(NEG_FS);
      return v;
   endfunction

   // Q1.16 product on the magnitude, truncated, sign put back afterwards
   function automatic int scale_q16(input int x, input int unsigned factor);
      longint unsigned mag;
      mag = (x < 0) ? -x : x;
      mag = (mag * factor) >> 16;
      return (x < 0) ? -int'(mag) : int'(mag);
   endfunction

   // Advances the model by one request and returns the response it gives
   function automatic pair_result_type predict_output(input op_type op,
         input logic signed [IN_W-1:0] in_l, input logic signed [IN_W-1:0] in_r);
      pair_result_type   res;
      int unsigned       gain;
      int                l_scaled;
      int                r_scaled;
      logic [PAIR_W-1:0] word;
      res = '0;
      case (op)
         OP_PUSH: begin
            gain = (volume > UNITY_GAIN) ? UNITY_GAIN : volume;
            l_scaled = scale_q16(clamp_full_scale(in_l), gain);
            r_scaled = scale_q16(clamp_full_scale(in_r), gain);
            if (stored_pairs >= PAIR_DEPTH) begin
               res.dropped = 1'b1;
            end else begin
               ring_copy[write_pos] = {l_scaled[SAMPLE_W-1:0], r_scaled[SAMPLE_W-1:0]};
               write_pos = (write_pos + 1) % PAIR_DEPTH;
               stored_pairs++;
               if (play_allowed && !playback_on && stored_pairs >= start_level)
                  playback_on = 1'b1;
            end
         end
         OP_PULL: begin
            if (playback_on) begin
               if (stored_pairs > 0) begin
                  word = ring_copy[read_pos];
                  read_pos = (read_pos + 1) % PAIR_DEPTH;
                  stored_pairs--;
                  held_left  = int'($signed(word[PAIR_W-1:SAMPLE_W]));
                  held_right = int'($signed(word[SAMPLE_W-1:0]));
               end else begin
                  // empty ring: repeat the last pair, decayed
                  res.underrun = 1'b1;
                  held_left  = scale_q16(held_left, DECAY_Q16);
                  held_right = scale_q16(held_right, DECAY_Q16);
               end
               res.left  = held_left[SAMPLE_W-1:0];
               res.right = held_right[SAMPLE_W-1:0];
            end
         end
         OP_CLEAR: begin
            read_pos     = 0;
            write_pos    = 0;
            stored_pairs = 0;
            playback_on  = 1'b0;
         end
         default: ;
      endcase
      res.playing = playback_on;
      res.fill    = stored_pairs[FILL_W-1:0];
      return res;
   endfunction

   // Model update and comparison, all at the rising edge
   always @(posedge clock) begin : watch
      pair_result_type want;
      if (reset) begin
         expected_pairs.delete();
         read_pos     = 0;
         write_pos    = 0;
         stored_pairs = 0;
         held_left    = 0;
         held_right   = 0;
         playback_on  = 1'b0;
         volume       = UNITY_GAIN;
         start_level  = PREBUF_RST;
         play_allowed = 1'b0;
         error_count  = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_VOLUME: volume       = csr_wdata[GAIN_W-1:0];
               CSR_PREBUF: start_level  = csr_wdata[PREBUF_W-1:0];
               CSR_PLAY:   play_allowed = csr_wdata[0];
               default: ;
            endcase
         end
         // responses first: a request accepted now cannot answer at this edge
         if (rsp_view.valid && rsp_view.ready) begin
            if (expected_pairs.size() == 0) begin
               flag_error("response transaction with no request outstanding");
            end else begin
               want = expected_pairs.pop_front();
               check_field("out_left", rsp_view.out_left, want.left);
               check_field("out_right", rsp_view.out_right, want.right);
               check_field("underrun", rsp_view.underrun, want.underrun);
               check_field("dropped", rsp_view.dropped, want.dropped);
               check_field("playing", rsp_view.playing, want.playing);
               check_field("fill_pairs", rsp_view.fill_pairs, want.fill);
            end
         end
         if (req_view.valid && req_view.ready)
            expected_pairs.push_back(predict_output(op_type'(req_view.op),
                                                    req_view.in_left, req_view.in_right));
      end
      outstanding = expected_pairs.size();
   end

endmodule

// ===== sim/stereo_audio_fifo_underrun_decay_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stereo_audio_fifo_underrun_decay_test: test top for the stereo audio FIFO
// Drives push, pull, clear and no-op transactions and register writes, with
// random gaps on the request side and random stalls on the response side.
// A directed opening covers clamping, volume limits, start threshold,
// underrun decay and clear; a decay pass runs a long underrun; random
// phases follow. Checking lives in fifo_playback_checker.
// ---------------------------------------------------------------------------

module stereo_audio_fifo_underrun_decay_test;
   import sfud_pkg::*;

   localparam int CYCLE_LIMIT      = 600000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES    = 8;
   localparam int PHASE_ITEMS      = 105;
   localparam int DECAY_PULLS      = 60;

   localparam logic signed [IN_W-1:0] SAMPLE_MAX = 18'sh1FFFF;
   localparam logic signed [IN_W-1:0] SAMPLE_MIN = 18'sh20000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   logic long_hold      = 1'b0;
   int   hold_cycles    = 0;
   int   cycle_count    = 0;
   int   mismatches;
   int   outstanding;

   sfud_req_if req_chan();
   sfud_rsp_if rsp_chan();

   stereo_audio_fifo_underrun_decay dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   fifo_playback_checker playback_check (
      .clock       (clock),
      .reset       (reset),
      .req_view    (req_chan),
      .rsp_view    (rsp_chan),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .error_count (mismatches),
      .outstanding (outstanding)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("stereo_audio_fifo_underrun_decay_test: FAIL");
         $finish;
      end
   end

   // Long receiver hold-off, counted once armed
   always @(posedge clock) begin
      if (long_hold && hold_cycles < LONG_HOLD_CYCLES)
         hold_cycles <= hold_cycles + 1;
   end

   // Receiver: random stalls plus the long hold-off
   always @(posedge clock) begin
      rsp_chan.ready <= !(long_hold && hold_cycles < LONG_HOLD_CYCLES) &&
                        ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic logic signed [IN_W-1:0] rand_sample();
      int v;
      case ($urandom_range(3))
         0: v = $urandom;
         1: v = int'($urandom_range(65534)) - 32767;
         2: begin
            case ($urandom_range(5))
               0: v = 131071;
               1: v = -131072;
               2: v = 32767;
               3: v = -32767;
               4: v = 32768;
               default: v = -32768;
            endcase
         end
         default: v = int'($urandom_range(200)) - 100;
      endcase
      return IN_W'(v);
   endfunction

   // One request transaction; valid is left high for a back-to-back follow-up
   task automatic send_item(input op_type op, input logic signed [IN_W-1:0] left,
                            input logic signed [IN_W-1:0] right);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.op       <= op;
      req_chan.in_left  <= left;
      req_chan.in_right <= right;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
   endtask

   // Stop sending and wait until every response is back
   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_register(input csr_index_type idx, input int unsigned value);
      wait_for_drain();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_directed();
      // reset settings: unity volume, threshold 1024, play disabled
      send_item(OP_PULL, IN_POS_FS, IN_NEG_FS);     // stopped: zeros
      send_item(OP_NOP, SAMPLE_MAX, SAMPLE_MIN);
      send_item(OP_PUSH, SAMPLE_MAX, SAMPLE_MIN);   // clamp both ways
      send_item(OP_PUSH, IN_POS_FS, IN_NEG_FS);
      send_item(OP_PUSH, 18'sd32768, -18'sd32768);
      send_item(OP_PUSH, 18'sd0, -18'sd1);
      set_register(CSR_PREBUF, 5);
      set_register(CSR_PLAY, 1);
      send_item(OP_PUSH, 18'sd100, -18'sd100);      // reaches threshold
      repeat (5) send_item(OP_PULL, 18'sd0, 18'sd0);
      repeat (2) send_item(OP_PULL, 18'sd0, 18'sd0); // underrun decay
      // play disable only blocks the start
      set_register(CSR_PLAY, 0);
      send_item(OP_PULL, 18'sd0, 18'sd0);
      send_item(OP_PUSH, 18'sd7, -18'sd7);
      send_item(OP_CLEAR, SAMPLE_MAX, SAMPLE_MIN);
      send_item(OP_PULL, 18'sd0, 18'sd0);
      // volume above unity, zero threshold
      set_register(CSR_VOLUME, 131071);
      set_register(CSR_PREBUF, 0);
      set_register(CSR_PLAY, 1);
      send_item(OP_PUSH, 18'sd12345, -18'sd12345);
      set_register(CSR_VOLUME, 0);
      send_item(OP_PUSH, IN_POS_FS, IN_NEG_FS);
      set_register(CSR_VOLUME, 1);
      send_item(OP_PUSH, IN_POS_FS, IN_NEG_FS);
      set_register(CSR_VOLUME, 32768);
      send_item(OP_PUSH, -18'sd3, 18'sd3);          // truncation toward zero
      repeat (4) send_item(OP_PULL, 18'sd0, 18'sd0);
   endtask

   // Long underrun: full scale left decays, small right decays to zero
   task automatic run_decay_test();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      set_register(CSR_VOLUME, UNITY_GAIN);
      set_register(CSR_PREBUF, 1);
      set_register(CSR_PLAY, 1);
      send_item(OP_CLEAR, 18'sd0, 18'sd0);
      send_item(OP_PUSH, IN_POS_FS, -18'sd40);
      repeat (DECAY_PULLS) send_item(OP_PULL, 18'sd0, 18'sd0);
   endtask

   // Bursts of pushes and pulls, with clears and no-ops mixed in
   task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                   input bit with_hold);
      int counted;
      int pick;
      int burst;
      int unsigned gain;
      int unsigned level;
      case ($urandom_range(3))
         0: gain = UNITY_GAIN;
         1: gain = $urandom_range(131071);
         default: gain = $urandom_range(65536);
      endcase
      if ($urandom_range(9) == 0)
         level = $urandom_range(1) ? 4095 : PAIR_DEPTH;
      else
         level = $urandom_range(12);
      set_register(CSR_VOLUME, gain);
      set_register(CSR_PREBUF, level);
      set_register(CSR_PLAY, $urandom_range(9) < 8);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      if (with_hold)
         long_hold <= 1'b1;
      counted = 0;
      while (counted < PHASE_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            burst = $urandom_range(10, 1);
            repeat (burst) send_item(OP_PUSH, rand_sample(), rand_sample());
            counted += burst;
         end else if (pick < 88) begin
            burst = $urandom_range(12, 1);
            repeat (burst) send_item(OP_PULL, rand_sample(), rand_sample());
            counted += burst;
         end else if (pick < 94) begin
            send_item(OP_CLEAR, rand_sample(), rand_sample());
            counted++;
         end else begin
            send_item(OP_NOP, rand_sample(), rand_sample());
         end
      end
   endtask

   initial begin
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= '0;
      csr_wdata         <= '0;
      req_chan.valid    <= 1'b0;
      req_chan.op       <= '0;
      req_chan.in_left  <= '0;
      req_chan.in_right <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_decay_test();
      run_random_phase(0, 0, 1'b1);
      run_random_phase(64, 0, 1'b0);
      run_random_phase(0, 64, 1'b0);
      run_random_phase(22, 22, 1'b0);

      wait_for_drain();
      if (mismatches == 0)
         $display("stereo_audio_fifo_underrun_decay_test: PASS");
      else
         $display("stereo_audio_fifo_underrun_decay_test: FAIL");
      $finish;
   end

endmodule
